// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/slft_pkg.sv -----
`timescale 1ns / 1ps

package slft_pkg;

  // Default geometry
  localparam int NUM_CORES_DEF        = 32;
  localparam int THREADS_PER_CORE_DEF = 2;
  localparam int LINES_PER_CORE_DEF   = 64;
  localparam int TAG_BITS_DEF         = 16;

  // Field widths
  localparam int ACTION_W  = 2;
  localparam int THREAD_W  = 6;
  localparam int LINE_W    = 7;
  localparam int REQ_W     = 16;
  localparam int STATE_W   = 2;
  localparam int COUNT_W   = 7;

  // Lines per counting group of the validated-line count
  localparam int GROUP_SIZE = 8;
  localparam int GROUP_W    = 4;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_FILL = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WAIT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

  // Line states
  localparam logic [STATE_W-1:0] LS_INVALID = 2'd0;
  localparam logic [STATE_W-1:0] LS_FILLING = 2'd1;
  localparam logic [STATE_W-1:0] LS_VALID   = 2'd2;

  typedef logic [STATE_W-1:0] line_state_t;

endpackage

// ----- src/scratchpad_line_fill_tracker_top.sv -----
`timescale 1ns / 1ps

// The done strobe follows the accepting edge through the execute state, the finish-stage
//   register and the done register. A new transaction is held off, busy high, until the
//   read and write-back of one core's line row in the status and tag memories is done.
// Reset: a clearing pass writes every status row invalid with busy high. Results are
//   never stalled by the receiver.
module scratchpad_line_fill_tracker_top #(
  parameter int NUM_CORES        = slft_pkg::NUM_CORES_DEF,
  parameter int THREADS_PER_CORE = slft_pkg::THREADS_PER_CORE_DEF,
  parameter int LINES_PER_CORE   = slft_pkg::LINES_PER_CORE_DEF,
  parameter int TAG_BITS         = slft_pkg::TAG_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [slft_pkg::ACTION_W-1:0] action,
  input  logic [slft_pkg::THREAD_W-1:0] thread_index,
  input  logic [slft_pkg::LINE_W-1:0]   line_index,
  input  logic [slft_pkg::REQ_W-1:0]    request_id,
  output logic                          done,
  output logic                          read_error,
  output logic [slft_pkg::STATE_W-1:0]  line_state,
  output logic [slft_pkg::COUNT_W-1:0]  lines_validated
);
  import slft_pkg::*;

  `include "assert_macros.svh"

  localparam int ADDR_BITS  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int LINE_BITS  = (LINES_PER_CORE > 1) ? $clog2(LINES_PER_CORE) : 1;
  localparam int NUM_GROUPS = (LINES_PER_CORE + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int NUM_THREADS = 1 << THREAD_W;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  typedef logic [LINES_PER_CORE-1:0][STATE_W-1:0]  status_row_t;
  typedef logic [LINES_PER_CORE-1:0][TAG_BITS-1:0] tag_row_t;

  logic [1:0] state, state_next;
  logic [ADDR_BITS-1:0] clr_addr;

  status_row_t status_mem [NUM_CORES];
  tag_row_t    tag_mem    [NUM_CORES];
  status_row_t status_rd, status_new;
  tag_row_t    tag_rd, tag_new;

  // Thread to core table, worked out at elaboration
  logic [THREAD_W-1:0] core_tab [NUM_THREADS];
  for (genvar t = 0; t < NUM_THREADS; t++) begin : g_core_tab
    localparam int CoreOfThread = t / THREADS_PER_CORE;
    assign core_tab[t] = THREAD_W'(CoreOfThread);
  end

  logic [THREAD_W-1:0] core_in;
  logic                accept;

  // Captured transaction
  logic [ACTION_W-1:0]  act_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic                 core_ok_q;
  logic                 line_ok_q;
  logic [LINE_BITS-1:0] lidx_q;
  logic [TAG_BITS-1:0]  tag_q;

  // Execute-stage results
  logic [LINES_PER_CORE-1:0] match;
  logic                      wr_status, wr_tag;
  logic                      err_new;
  line_state_t               state_rd_new;
  logic [NUM_GROUPS-1:0][GROUP_W-1:0] grp_cnt_new;

  // Finish-stage registers
  logic                               fin_pend;
  logic                               fin_err;
  line_state_t                        fin_state;
  logic [NUM_GROUPS-1:0][GROUP_W-1:0] grp_cnt;
  logic [COUNT_W-1:0]                 count_sum;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign core_in = core_tab[thread_index];

  // Sequence clear, idle and execute
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == ADDR_BITS'(NUM_CORES - 1)) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  // Capture the transaction and decode core and line range
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q     <= action;
      addr_q    <= ADDR_BITS'(core_in);
      core_ok_q <= ({1'b0, 11'(core_in)} < 12'(NUM_CORES));
      line_ok_q <= ({1'b0, line_index} < 8'(LINES_PER_CORE));
      lidx_q    <= LINE_BITS'(line_index);
      tag_q     <= TAG_BITS'(request_id);
    end
  end

  // Read the core's row on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      status_rd <= status_mem[ADDR_BITS'(core_in)];
      tag_rd    <= tag_mem[ADDR_BITS'(core_in)];
    end
  end

  // Modify the row: lane compare, fill update, read lookup
  always_comb begin
    status_new   = status_rd;
    tag_new      = tag_rd;
    wr_status    = 1'b0;
    wr_tag       = 1'b0;
    err_new      = 1'b0;
    state_rd_new = LS_INVALID;
    for (int k = 0; k < LINES_PER_CORE; k++) begin
      match[k] = (act_q == ACT_WAIT) && core_ok_q &&
                 (status_rd[k] == LS_FILLING) && (tag_rd[k] == tag_q);
    end
    case (act_q)
      ACT_FILL: begin
        if (core_ok_q && line_ok_q) begin
          status_new[lidx_q] = LS_FILLING;
          tag_new[lidx_q]    = tag_q;
          wr_status          = 1'b1;
          wr_tag             = 1'b1;
        end
      end
      ACT_WAIT: begin
        for (int k = 0; k < LINES_PER_CORE; k++) begin
          if (match[k]) status_new[k] = LS_VALID;
        end
        wr_status = core_ok_q;
      end
      ACT_READ: begin
        if (core_ok_q && line_ok_q) state_rd_new = status_rd[lidx_q];
        err_new = (state_rd_new != LS_VALID);
      end
      default: ;
    endcase
  end

  // Count matches per group of lines
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_cnt_new[g] = '0;
      for (int b = 0; b < GROUP_SIZE; b++) begin
        if (g * GROUP_SIZE + b < LINES_PER_CORE) begin
          grp_cnt_new[g] = grp_cnt_new[g] + GROUP_W'(match[g * GROUP_SIZE + b]);
        end
      end
    end
  end

  // Write back the row, or clear it during the reset pass
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      status_mem[clr_addr] <= '0;
    end else if (state == S_EXEC) begin
      if (wr_status) status_mem[addr_q] <= status_new;
      if (wr_tag)    tag_mem[addr_q]    <= tag_new;
    end
  end

  // Hold execute results for the finish stage
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_pend <= 1'b0;
    end else begin
      fin_pend <= (state == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      fin_err   <= err_new;
      fin_state <= state_rd_new;
      grp_cnt   <= grp_cnt_new;
    end
  end

  // Sum the group counts
  always_comb begin
    count_sum = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      count_sum = count_sum + COUNT_W'(grp_cnt[g]);
    end
  end

  // Drive the result strobe and fields
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin_pend;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_pend) begin
      read_error      <= fin_err;
      line_state      <= fin_state;
      lines_validated <= count_sum;
    end
  end

  `ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == S_EXEC)
  `ASSERT_SAME(a_done_after_exec, clk, rst, done, $past(state == S_IDLE))
  `ASSERT_SAME(a_wait_no_error, clk, rst, done && (lines_validated != '0), !read_error)
  `ASSERT_SAME(a_count_bound, clk, rst, done,
               {1'b0, lines_validated} <= 8'(LINES_PER_CORE))

endmodule

// ----- tb/tb_scratchpad_line_fill_tracker_top.sv -----
`timescale 1ns / 1ps

module tb_scratchpad_line_fill_tracker_top;
  import slft_pkg::*;

  localparam int NUM_CORES        = NUM_CORES_DEF;
  localparam int THREADS_PER_CORE = THREADS_PER_CORE_DEF;
  localparam int LINES_PER_CORE   = LINES_PER_CORE_DEF;
  localparam int TAG_BITS         = TAG_BITS_DEF;
  localparam int TOTAL_LINES      = NUM_CORES * LINES_PER_CORE;
  localparam logic [REQ_W-1:0] TAG_MASK =
    (TAG_BITS >= REQ_W) ? '1 : REQ_W'((64'd1 << TAG_BITS) - 1);
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_LIMIT  = 30;

  typedef struct packed {
    logic               read_error;
    line_state_t        line_state;
    logic [COUNT_W-1:0] lines_validated;
  } line_report_t;

  // Track line state per core and match each done strobe to its access
  class fill_tracker_scoreboard_t;
    line_state_t        status [TOTAL_LINES];
    logic [REQ_W-1:0]   tags [TOTAL_LINES];
    line_report_t       pending_reports [$];
    int                 errors;

    function new();
      foreach (status[i]) status[i] = LS_INVALID;
      foreach (tags[i]) tags[i] = '0;
      errors = 0;
    endfunction

    // Apply one accepted access and queue the report it must produce
    function void note_access(logic [ACTION_W-1:0] act, logic [THREAD_W-1:0] thr,
                              logic [LINE_W-1:0] ln, logic [REQ_W-1:0] rid);
      int           core;
      int           base;
      bit           core_ok;
      bit           line_ok;
      logic [REQ_W-1:0] tg;
      line_report_t exp;
      core    = int'(thr) / THREADS_PER_CORE;
      core_ok = core < NUM_CORES;
      line_ok = int'(ln) < LINES_PER_CORE;
      base    = core_ok ? core * LINES_PER_CORE : 0;
      tg      = rid & TAG_MASK;
      exp     = '0;
      case (act)
        ACT_FILL: begin
          if (core_ok && line_ok) begin
            status[base + int'(ln)] = LS_FILLING;
            tags[base + int'(ln)]   = tg;
          end
        end
        ACT_WAIT: begin
          if (core_ok) begin
            for (int k = 0; k < LINES_PER_CORE; k++) begin
              if (status[base + k] == LS_FILLING && tags[base + k] == tg) begin
                status[base + k] = LS_VALID;
                exp.lines_validated = exp.lines_validated + 1'b1;
              end
            end
          end
        end
        ACT_READ: begin
          if (core_ok && line_ok) begin
            exp.line_state = status[base + int'(ln)];
            exp.read_error = (status[base + int'(ln)] != LS_VALID);
          end else begin
            exp.read_error = 1'b1;
          end
        end
        default: ;
      endcase
      pending_reports = {pending_reports, exp};
    endfunction

    task report_mismatch(string msg);
      if (errors < PRINT_LIMIT) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Compare one result field by field with the oldest pending report
    task check_report(logic err, line_state_t st, logic [COUNT_W-1:0] cnt);
      line_report_t exp;
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: err=%0d state=%0d count=%0d",
                                  err, st, cnt));
        return;
      end
      exp = pending_reports.pop_front();
      if (err !== exp.read_error)
        report_mismatch($sformatf("read_error %0d, want %0d", err, exp.read_error));
      if (st !== exp.line_state)
        report_mismatch($sformatf("line_state %0d, want %0d", st, exp.line_state));
      if (cnt !== exp.lines_validated)
        report_mismatch($sformatf("lines_validated %0d, want %0d", cnt, exp.lines_validated));
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [ACTION_W-1:0] action;
  logic [THREAD_W-1:0] thread_index;
  logic [LINE_W-1:0]   line_index;
  logic [REQ_W-1:0]    request_id;
  logic                done;
  logic                read_error;
  line_state_t         line_state;
  logic [COUNT_W-1:0]  lines_validated;

  fill_tracker_scoreboard_t sb;
  bit idle_on;
  int items_counted;
  int cycle_count = 0;

  scratchpad_line_fill_tracker_top DUT (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .thread_index    (thread_index),
    .line_index      (line_index),
    .request_id      (request_id),
    .done            (done),
    .read_error      (read_error),
    .line_state      (line_state),
    .lines_validated (lines_validated)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("scratchpad_line_fill_tracker_top: mismatch");
      $finish;
    end
  end

  // Check every result in the cycle of its strobe
  always @(posedge clk) begin
    if (!rst && done) sb.check_report(read_error, line_state, lines_validated);
  end

  // Drive one transaction and hold it until accepted; start stays high for the next
  task automatic issue_access(logic [ACTION_W-1:0] act, logic [THREAD_W-1:0] thr,
                              logic [LINE_W-1:0] ln, logic [REQ_W-1:0] rid);
    if (idle_on && $urandom_range(99) < 37) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start        <= 1'b1;
    action       <= act;
    thread_index <= thr;
    line_index   <= ln;
    request_id   <= rid;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_access(act, thr, ln, rid);
    if (!(act == ACT_UNUSED || (act == ACT_FILL && int'(ln) >= LINES_PER_CORE)))
      items_counted++;
  endtask

  // Hold off until every pending result has arrived
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_reports.size() != 0) @(posedge clk);
  endtask

  function automatic logic [THREAD_W-1:0] thread_of(int core);
    return THREAD_W'(core * THREADS_PER_CORE + $urandom_range(THREADS_PER_CORE - 1));
  endfunction

  function automatic logic [REQ_W-1:0] pick_tag();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 16'h5555;
      3: return 16'hAAAA;
      default: return REQ_W'($urandom);
    endcase
  endfunction

  // Fill a few lines of one core with one tag, wait on it, then read back
  task automatic run_fill_wait();
    int               core;
    int               n;
    logic [LINE_W-1:0] ln;
    logic [REQ_W-1:0] tg;
    core = $urandom_range(NUM_CORES - 1);
    tg   = pick_tag();
    n    = $urandom_range(1, 8);
    repeat (n) begin
      ln = LINE_W'($urandom_range(LINES_PER_CORE - 1));
      if ($urandom_range(9) == 0) ln = LINE_W'($urandom_range(LINES_PER_CORE, 127));
      issue_access(ACT_FILL, thread_of(core), ln, tg);
      if ($urandom_range(3) == 0)
        issue_access(ACT_READ, thread_of(core), LINE_W'($urandom_range(127)), REQ_W'($urandom));
    end
    // refill one line with a different tag so the wait must skip it
    if ($urandom_range(3) == 0)
      issue_access(ACT_FILL, thread_of(core), ln, tg ^ REQ_W'($urandom_range(1, 65535)));
    issue_access(ACT_WAIT, thread_of(core), LINE_W'($urandom_range(127)), tg);
    repeat ($urandom_range(0, 3))
      issue_access(ACT_READ, thread_of(core), LINE_W'($urandom_range(LINES_PER_CORE - 1)),
                   REQ_W'($urandom));
    if ($urandom_range(4) == 0) issue_access(ACT_READ, thread_of(core), ln, REQ_W'($urandom));
  endtask

  // Fill every line of one core with one tag so a single wait validates them all
  task automatic run_full_core();
    int               core;
    logic [REQ_W-1:0] tg;
    core = $urandom_range(NUM_CORES - 1);
    tg   = pick_tag();
    for (int k = 0; k < LINES_PER_CORE; k++)
      issue_access(ACT_FILL, thread_of(core), LINE_W'(k), tg);
    issue_access(ACT_WAIT, thread_of(core), LINE_W'($urandom_range(127)), tg);
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 5))
      issue_access(ACTION_W'($urandom_range(3)), THREAD_W'($urandom_range(63)),
                   LINE_W'($urandom_range(127)), REQ_W'($urandom));
  endtask

  initial begin
    int  pick;
    bit  drained_mid;
    sb            = new();
    idle_on       = 1'b1;
    items_counted = 0;
    drained_mid   = 1'b0;
    rst          <= 1'b1;
    start        <= 1'b0;
    action       <= ACT_FILL;
    thread_index <= '0;
    line_index   <= '0;
    request_id   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every action, refills, out-of-range lines, unused action
    issue_access(ACT_READ,   6'd0,  7'd0,   16'h0000);
    issue_access(ACT_FILL,   6'd0,  7'd0,   16'h0000);
    issue_access(ACT_READ,   6'd0,  7'd0,   16'hFFFF);
    issue_access(ACT_FILL,   6'd1,  7'd63,  16'h0000);
    issue_access(ACT_WAIT,   6'd1,  7'd127, 16'h0000);
    issue_access(ACT_READ,   6'd0,  7'd63,  16'h0000);
    issue_access(ACT_WAIT,   6'd0,  7'd0,   16'h0000);
    issue_access(ACT_FILL,   6'd63, 7'd63,  16'hFFFF);
    issue_access(ACT_FILL,   6'd62, 7'd0,   16'hFFFF);
    issue_access(ACT_FILL,   6'd63, 7'd127, 16'hFFFF);
    issue_access(ACT_READ,   6'd63, 7'd127, 16'hFFFF);
    issue_access(ACT_READ,   6'd62, 7'd64,  16'h0000);
    issue_access(ACT_FILL,   6'd63, 7'd0,   16'h1234);
    issue_access(ACT_WAIT,   6'd63, 7'd0,   16'hFFFF);
    issue_access(ACT_READ,   6'd63, 7'd0,   16'h0000);
    issue_access(ACT_FILL,   6'd0,  7'd0,   16'hAAAA);
    issue_access(ACT_READ,   6'd1,  7'd0,   16'h5555);
    issue_access(ACT_UNUSED, 6'd42, 7'd100, 16'h5555);
    issue_access(ACT_WAIT,   6'd0,  7'd0,   16'hAAAA);
    issue_access(ACT_WAIT,   6'd62, 7'd0,   16'h1234);
    issue_access(ACT_READ,   6'd62, 7'd63,  16'h0000);
    issue_access(ACT_WAIT,   6'd5,  7'd0,   16'h7777);
    drain_results();

    // Random: mostly fill-then-wait sequences, some full-core fills, some noise
    items_counted = 0;
    while (items_counted < RANDOM_ITEMS) begin
      idle_on = !(items_counted >= 400 && items_counted < 600);
      if (!drained_mid && items_counted >= 800) begin
        drain_results();
        drained_mid = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 72) run_fill_wait();
      else if (pick < 74) run_full_core();
      else run_noise();
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_reports.size() == 0)
      $display("scratchpad_line_fill_tracker_top: match");
    else
      $display("scratchpad_line_fill_tracker_top: mismatch");
    $finish;
  end

endmodule
